// ===== sv/cmt_pkg.sv =====
// Shared types and constants for the config-map tokenizer.
// Used by cmt_front, cmt_queue, cmt_back and config_map_tokenizer_top.
package cmt_pkg;

  // Column tab stop default and position limits
  localparam int          TAB_STOP_DEF = 8;
  localparam logic [11:0] COL_MAX      = 12'hFFF;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 5;

  // Token kinds
  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_EQUALS = 4'd1;
  localparam logic [3:0] KIND_COMMA  = 4'd2;
  localparam logic [3:0] KIND_SEMI   = 4'd3;
  localparam logic [3:0] KIND_LBRACK = 4'd4;
  localparam logic [3:0] KIND_RBRACK = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_LIT    = 4'd8;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_STRING  = 2'd1;
  localparam logic [1:0] ERR_COMMENT = 2'd2;

  // One result word, without position
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    logic       quoted;
    logic [1:0] err;
  } result_t;

  // Results caused by one input word; both share one position
  typedef struct packed {
    result_t     r0;
    result_t     r1;
    logic        two;
    logic [15:0] line;
    logic [11:0] col;
  } entry_t;

  // Build a result word; character reads as zero when not valid
  function automatic result_t mk_result(logic [3:0] kind, logic [7:0] ch, logic valid,
                                        logic tend, logic quoted, logic [1:0] err);
    result_t r;
    r.kind   = kind;
    r.ch     = valid ? ch : 8'd0;
    r.valid  = valid;
    r.tend   = tend;
    r.quoted = quoted;
    r.err    = err;
    return r;
  endfunction

endpackage

// ===== sv/cmt_front.sv =====
// Front end of the tokenizer: lexer mode, comment tracking and text position.
// Classifies each accepted word into zero, one or two results. Uses cmt_pkg.
module cmt_front #(
  parameter int TAB_STOP = cmt_pkg::TAB_STOP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  input  logic             end_mark,
  output logic             push,
  output cmt_pkg::entry_t  entry
);
  import cmt_pkg::*;

  localparam int PW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  // Phase of column zero follows the unsigned wrap of (column - 1)
  localparam logic [PW-1:0] PH_RESET = PW'(64'hFFFF_FFFF % 64'(TAB_STOP));
  localparam logic [PW-1:0] PH_TAB0  = PW'(TAB_STOP - 1 - int'(PH_RESET));
  localparam logic [PW-1:0] PH_LAST  = PW'(TAB_STOP - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [6:0] {
    MODE_IDLE   = 7'b0000001,
    MODE_BARE   = 7'b0000010,
    MODE_QUOTED = 7'b0000100,
    MODE_QESC   = 7'b0001000,
    MODE_SLASH  = 7'b0010000,
    MODE_BLOCK  = 7'b0100000,
    MODE_LINE   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [15:0]   line;
    logic [11:0]   col;
    logic [PW-1:0] ph;
  } pos_t;

  typedef struct packed {
    logic    has;
    result_t res;
    mode_t   mode;
  } bt_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] b);
    logic [3:0] k;
    case (b)
      8'h3D:   k = KIND_EQUALS;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic ends_bare(logic [7:0] b);
    logic [3:0] k;
    k = punct_kind(b);
    return is_ws(b) || ((k != KIND_EOF) && (k != KIND_LBRACK) && (k != KIND_LBRACE));
  endfunction

  // Handle a byte seen between tokens
  function automatic bt_t between(logic [7:0] b);
    bt_t        t;
    logic [3:0] k;
    k      = punct_kind(b);
    t.has  = 1'b0;
    t.res  = '0;
    t.mode = MODE_IDLE;
    if (is_ws(b)) begin
      t.mode = MODE_IDLE;
    end else if (k != KIND_EOF) begin
      t.has = 1'b1;
      t.res = mk_result(k, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
    end else if (b == CH_QUOTE) begin
      t.has  = 1'b1;
      t.res  = mk_result(KIND_LIT, b, 1'b1, 1'b0, 1'b1, ERR_NONE);
      t.mode = MODE_QUOTED;
    end else if (b == CH_SLASH) begin
      t.mode = MODE_SLASH;
    end else begin
      t.has  = 1'b1;
      t.res  = mk_result(KIND_LIT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      t.mode = MODE_BARE;
    end
    return t;
  endfunction

  // Step the position past the previous byte
  function automatic pos_t advance_pos(pos_t cur, logic [7:0] prev);
    pos_t        nxt;
    logic [12:0] c13;
    nxt = cur;
    c13 = {1'b0, cur.col};
    if (prev == CH_LF) begin
      if (cur.line != LINE_MAX) begin
        nxt.line = cur.line + 16'd1;
      end
      c13    = 13'd1;
      nxt.ph = '0;
    end else if (prev == CH_TAB) begin
      c13    = {1'b0, cur.col} + 13'(TAB_STOP) - 13'(cur.ph);
      nxt.ph = (cur.col == 12'd0) ? PH_TAB0 : '0;
    end else if (prev != CH_CR) begin
      c13 = {1'b0, cur.col} + 13'd1;
      if (cur.col == 12'd0 || cur.ph == PH_LAST) begin
        nxt.ph = '0;
      end else begin
        nxt.ph = cur.ph + 1'b1;
      end
    end
    nxt.col = (c13 > {1'b0, COL_MAX}) ? COL_MAX : c13[11:0];
    return nxt;
  endfunction

  mode_t       mode_r, mode_nxt;
  pos_t        pos_r, pos_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        star_r, star_nxt;

  pos_t        pos_a, pos_b, pos_e;
  result_t     r0, r1;
  logic [1:0]  cnt;
  logic        fin;
  bt_t         bt;

  // Classify the incoming word
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    star_nxt = star_r;
    r0       = '0;
    r1       = '0;
    cnt      = 2'd0;
    fin      = 1'b0;
    pos_a    = advance_pos(pos_r, prev_r);
    pos_b    = advance_pos(pos_a, CH_NUL);
    pos_e    = pos_a;
    bt       = between(text_byte);

    if (end_mark) begin
      fin   = 1'b1;
      pos_e = (pos_r.col != 12'd0) ? pos_a : pos_r;
    end else if (text_byte == CH_NUL) begin
      fin   = 1'b1;
      pos_e = (pos_a.col != 12'd0) ? pos_b : pos_a;
    end else begin
      pos_nxt  = pos_a;
      prev_nxt = text_byte;
      case (mode_r)
        MODE_BARE: begin
          if (ends_bare(text_byte)) begin
            r0       = mk_result(KIND_LIT, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
            r1       = bt.res;
            cnt      = bt.has ? 2'd2 : 2'd1;
            mode_nxt = bt.mode;
          end else begin
            r0  = mk_result(KIND_LIT, text_byte, 1'b1, 1'b0, 1'b0, ERR_NONE);
            cnt = 2'd1;
          end
        end
        MODE_QUOTED: begin
          if (text_byte == CH_QUOTE) begin
            r0       = mk_result(KIND_LIT, text_byte, 1'b1, 1'b1, 1'b1, ERR_NONE);
            cnt      = 2'd1;
            mode_nxt = MODE_IDLE;
          end else if (text_byte == CH_BSL) begin
            mode_nxt = MODE_QESC;
          end else begin
            r0  = mk_result(KIND_LIT, text_byte, 1'b1, 1'b0, 1'b1, ERR_NONE);
            cnt = 2'd1;
          end
        end
        MODE_QESC: begin
          r0       = mk_result(KIND_LIT, text_byte, 1'b1, 1'b0, 1'b1, ERR_NONE);
          cnt      = 2'd1;
          mode_nxt = MODE_QUOTED;
        end
        MODE_SLASH: begin
          if (text_byte == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else if (text_byte == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (ends_bare(text_byte)) begin
            r0       = mk_result(KIND_LIT, CH_SLASH, 1'b1, 1'b1, 1'b0, ERR_NONE);
            r1       = bt.res;
            cnt      = bt.has ? 2'd2 : 2'd1;
            mode_nxt = bt.mode;
          end else begin
            r0       = mk_result(KIND_LIT, CH_SLASH, 1'b1, 1'b0, 1'b0, ERR_NONE);
            r1       = mk_result(KIND_LIT, text_byte, 1'b1, 1'b0, 1'b0, ERR_NONE);
            cnt      = 2'd2;
            mode_nxt = MODE_BARE;
          end
        end
        MODE_BLOCK: begin
          if (text_byte == CH_SLASH && star_r) begin
            mode_nxt = MODE_IDLE;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (text_byte == CH_STAR);
          end
        end
        MODE_LINE: begin
          if (text_byte == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          r0       = bt.res;
          cnt      = bt.has ? 2'd1 : 2'd0;
          mode_nxt = bt.mode;
        end
      endcase
    end

    // Close the text: flush the open token, then EOF or error
    if (fin) begin
      case (mode_r)
        MODE_BARE: begin
          r0  = mk_result(KIND_LIT, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          r1  = mk_result(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          cnt = 2'd2;
        end
        MODE_SLASH: begin
          r0  = mk_result(KIND_LIT, CH_SLASH, 1'b1, 1'b1, 1'b0, ERR_NONE);
          r1  = mk_result(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          cnt = 2'd2;
        end
        MODE_QUOTED, MODE_QESC: begin
          r0  = mk_result(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_STRING);
          cnt = 2'd1;
        end
        MODE_BLOCK: begin
          r0  = mk_result(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_COMMENT);
          cnt = 2'd1;
        end
        default: begin
          r0  = mk_result(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          cnt = 2'd1;
        end
      endcase
      mode_nxt = MODE_IDLE;
      pos_nxt  = '{line: 16'd1, col: 12'd0, ph: PH_RESET};
      prev_nxt = 8'd0;
      star_nxt = 1'b0;
    end
  end

  // Hand results to the queue
  assign push       = accept && (cnt != 2'd0);
  assign entry.r0   = r0;
  assign entry.r1   = r1;
  assign entry.two  = (cnt == 2'd2);
  assign entry.line = pos_e.line;
  assign entry.col  = pos_e.col;

  // Advance lexer state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '{line: 16'd1, col: 12'd0, ph: PH_RESET};
      prev_r <= 8'd0;
      star_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      star_r <= star_nxt;
    end
  end

endmodule

// ===== sv/cmt_queue.sv =====
// Short queue of result entries between tokenizer front and back.
// Holds FIFO_DEPTH entries; uses cmt_pkg.
module cmt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cmt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            nempty,
  output cmt_pkg::entry_t head
);
  import cmt_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  entry_t          slot_r [FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full   = (count_r == CW'(FIFO_DEPTH));
  assign nempty = (count_r != '0);
  assign head   = slot_r[rd_ptr_r];

  // Store entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cmt_back.sv =====
// Back end of the tokenizer: unpacks queued entries into output words.
// Holds the current entry in a register stage; uses cmt_pkg.
module cmt_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             nempty,
  input  cmt_pkg::entry_t                  head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [cmt_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);
  import cmt_pkg::*;

  entry_t   cur_r;
  logic     cur_valid_r;
  logic     sel_r;
  result_t  res;
  logic     last;
  logic     fire;
  logic     load;

  // Pick the word to show
  assign res  = sel_r ? cur_r.r1 : cur_r.r0;
  assign last = sel_r || !cur_r.two;
  assign fire = cur_valid_r && out_tready;
  assign load = !cur_valid_r || (fire && last);
  assign pop  = load && nempty;

  assign out_tvalid = cur_valid_r;
  assign out_tlast  = last;
  assign out_tuser  = {res.valid, res.kind};
  assign out_tdata  = {cur_r.col, cur_r.line, res.err, res.quoted, res.tend, res.ch};

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  // Step through the entry's words and refill from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      cur_valid_r <= nempty;
      sel_r       <= 1'b0;
    end else if (fire) begin
      sel_r <= 1'b1;
    end
  end

endmodule

// ===== sv/config_map_tokenizer_top.sv =====
// Top level of the config-map tokenizer.
// Instantiates cmt_front, cmt_queue and cmt_back; uses cmt_pkg.
//
// Usage:
//   Input channel in_*: one text byte per word in in_tdata; in_tlast marks the
//   end of the text (byte ignored). A zero byte also ends the text.
//   Output channel out_*: one token character or token mark per word. out_tlast
//   flags the last word caused by one input word.
//   The queue stores the results of each accepted input word, and the output stage
//   then loads them before the first word caused by that input word appears.
//   Throughput: one input word per cycle while the queue has room; an input word
//   that makes two results takes two output slots, one that makes none takes no output slot.
//   The lexer mode and text position update once per accepted byte in the
//   front end, so that loop sets the input rate.
//   A four-entry queue sits between front and back: when the receiver stalls,
//   in_tready drops only once the queue is full.
//   Reset: rst_n (synchronous, active low) empties the queue and output stage
//   and puts the lexer between tokens at line 1, column 0. After each end of
//   text the lexer returns to the same state on its own.
module config_map_tokenizer_top #(
  parameter int TAB_STOP = cmt_pkg::TAB_STOP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cmt_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] text_byte
  input  logic                             in_tlast,   // end_mark
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] char_value, [8] token_end, [9] is_quoted, [11:10] error_code,
  // [27:12] line_number, [39:28] column_number
  output logic [cmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [cmt_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [3:0] token_kind, [4] char_valid
  output logic                             out_tlast   // run_last
);
  import cmt_pkg::*;

  logic    accept;
  logic    push;
  logic    full;
  logic    pop;
  logic    nempty;
  entry_t  push_entry;
  entry_t  head;

  // Take a word whenever the queue has room
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  cmt_front #(
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_tdata),
    .end_mark  (in_tlast),
    .push      (push),
    .entry     (push_entry)
  );

  cmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .nempty     (nempty),
    .head       (head)
  );

  cmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nempty     (nempty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for config_map_tokenizer_top: random and directed config text
// goes in, and every output word is checked against a predictor kept in step here.
// Depends on cmt_pkg and the tokenizer RTL only.
`timescale 1ns / 100ps

module tb_top;
  import cmt_pkg::*;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 280;

  // Characters the lexer treats specially
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    LX_IDLE, LX_BARE, LX_QUOTED, LX_ESCAPE, LX_SLASH, LX_BLOCK, LX_LINE
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] text;
    logic       stop;
  } text_word_t;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic        valid;
    logic        tend;
    logic        quoted;
    logic [1:0]  err;
    logic [15:0] line;
    logic [11:0] col;
    logic        last;
  } token_word_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  logic in_fire = 1'b0;

  text_word_t  pending_words[$];
  token_word_t expected_tokens[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Lexer state as seen by the predictor
  lex_mode_t   lex_state;
  logic [15:0] text_line;
  logic [11:0] text_col;
  logic [7:0]  last_byte;
  logic        star_pending;

  config_map_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit ends_bare_ch(logic [7:0] b);
    return is_space(b) || b == CH_EQ || b == CH_COMMA || b == CH_SEMI ||
           b == CH_RBRACK || b == CH_RBRACE;
  endfunction

  // KIND_EOF marks a byte that is no punctuation
  function automatic logic [3:0] punct_kind(logic [7:0] b);
    case (b)
      CH_EQ:     return KIND_EQUALS;
      CH_COMMA:  return KIND_COMMA;
      CH_SEMI:   return KIND_SEMI;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      default:   return KIND_EOF;
    endcase
  endfunction

  task automatic reset_lexer();
    lex_state    = LX_IDLE;
    text_line    = 16'd1;
    text_col     = 12'd0;
    last_byte    = CH_NUL;
    star_pending = 1'b0;
  endtask

  // Move the position past the previous byte; tabs jump to the next stop
  task automatic advance_position();
    int c;
    c = int'(text_col);
    if (last_byte == CH_LF) begin
      if (text_line != LINE_MAX) text_line = text_line + 16'd1;
      c = 1;
    end else if (last_byte == CH_TAB) begin
      c = c + TAB_STOP_DEF - ((c - 1) % TAB_STOP_DEF);
    end else if (last_byte != CH_CR) begin
      c = c + 1;
    end
    text_col = (c > int'(COL_MAX)) ? COL_MAX : c[11:0];
  endtask

  task automatic emit_token(logic [3:0] kind, logic [7:0] ch, logic valid, logic tend,
                            logic quoted, logic [1:0] err);
    token_word_t t;
    t.kind   = kind;
    t.ch     = valid ? ch : 8'd0;
    t.valid  = valid;
    t.tend   = tend;
    t.quoted = quoted;
    t.err    = err;
    t.line   = text_line;
    t.col    = text_col;
    t.last   = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  // Handle a byte while between tokens
  task automatic start_token(logic [7:0] b);
    logic [3:0] kind;
    kind = punct_kind(b);
    if (is_space(b)) begin
      lex_state = LX_IDLE;
    end else if (kind != KIND_EOF) begin
      emit_token(kind, CH_NUL, 1'b0, 1'b1, 1'b0, ERR_NONE);
      lex_state = LX_IDLE;
    end else if (b == CH_QUOTE) begin
      emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b1, ERR_NONE);
      lex_state = LX_QUOTED;
    end else if (b == CH_SLASH) begin
      lex_state = LX_SLASH;
    end else begin
      emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      lex_state = LX_BARE;
    end
  endtask

  // Close the text: flush an open literal, then EOF or the error for an open construct
  task automatic finish_text();
    logic [1:0] err;
    err = ERR_NONE;
    if (text_col != 12'd0) advance_position();
    case (lex_state)
      LX_BARE:             emit_token(KIND_LIT, CH_NUL, 1'b0, 1'b1, 1'b0, ERR_NONE);
      LX_SLASH:            emit_token(KIND_LIT, CH_SLASH, 1'b1, 1'b1, 1'b0, ERR_NONE);
      LX_QUOTED, LX_ESCAPE: err = ERR_STRING;
      LX_BLOCK:            err = ERR_COMMENT;
      default: ;
    endcase
    emit_token(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b0, err);
    reset_lexer();
  endtask

  // Predict the output words for one accepted input word
  task automatic lex_word(logic [7:0] b, logic stop);
    int depth0;
    depth0 = expected_tokens.size();
    if (stop) begin
      finish_text();
    end else begin
      advance_position();
      last_byte = b;
      if (b == CH_NUL) begin
        finish_text();
      end else begin
        case (lex_state)
          LX_BARE: begin
            if (ends_bare_ch(b)) begin
              emit_token(KIND_LIT, CH_NUL, 1'b0, 1'b1, 1'b0, ERR_NONE);
              start_token(b);
            end else begin
              emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
          end
          LX_QUOTED: begin
            if (b == CH_QUOTE) begin
              emit_token(KIND_LIT, b, 1'b1, 1'b1, 1'b1, ERR_NONE);
              lex_state = LX_IDLE;
            end else if (b == CH_BSLASH) begin
              lex_state = LX_ESCAPE;
            end else begin
              emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b1, ERR_NONE);
            end
          end
          LX_ESCAPE: begin
            emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b1, ERR_NONE);
            lex_state = LX_QUOTED;
          end
          LX_SLASH: begin
            if (b == CH_STAR) begin
              lex_state    = LX_BLOCK;
              star_pending = 1'b0;
            end else if (b == CH_SLASH) begin
              lex_state = LX_LINE;
            end else if (ends_bare_ch(b)) begin
              emit_token(KIND_LIT, CH_SLASH, 1'b1, 1'b1, 1'b0, ERR_NONE);
              start_token(b);
            end else begin
              emit_token(KIND_LIT, CH_SLASH, 1'b1, 1'b0, 1'b0, ERR_NONE);
              emit_token(KIND_LIT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
              lex_state = LX_BARE;
            end
          end
          LX_BLOCK: begin
            if (b == CH_SLASH && star_pending) begin
              lex_state    = LX_IDLE;
              star_pending = 1'b0;
            end else begin
              star_pending = (b == CH_STAR);
            end
          end
          LX_LINE: begin
            if (b == CH_LF) lex_state = LX_IDLE;
          end
          default: start_token(b);
        endcase
      end
    end
    if (expected_tokens.size() > depth0)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // Present the next text word once the current one is taken
  always @(negedge clk) begin : drive_text
    text_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_fire || !in_tvalid) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.text;
        in_tlast  <= w.stop;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output at random; hold it off once for a long stretch
  always @(negedge clk) begin : drive_ready
    int  hold_left;
    bit  hold_done;
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on each accepted text word, compare each accepted token word
  always @(posedge clk) begin : watch
    token_word_t t;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) lex_word(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token word: tdata %h tuser %h", out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          t = expected_tokens.pop_front();
          check_field("token_kind",    32'(t.kind),   32'(out_tuser[3:0]));
          check_field("char_valid",    32'(t.valid),  32'(out_tuser[4]));
          check_field("char_value",    32'(t.ch),     32'(out_tdata[7:0]));
          check_field("token_end",     32'(t.tend),   32'(out_tdata[8]));
          check_field("is_quoted",     32'(t.quoted), 32'(out_tdata[9]));
          check_field("error_code",    32'(t.err),    32'(out_tdata[11:10]));
          check_field("line_number",   32'(t.line),   32'(out_tdata[27:12]));
          check_field("column_number", 32'(t.col),    32'(out_tdata[39:28]));
          check_field("run_last",      32'(t.last),   32'(out_tlast));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_word(logic [7:0] b, logic stop);
    text_word_t w;
    w.text = b;
    w.stop = stop;
    pending_words.insert(pending_words.size(), w);
  endtask

  // End mark; the byte beside it is ignored, so make it random
  task automatic add_end();
    add_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] bare_char(bit first);
    logic [7:0] b;
    if ($urandom_range(3) != 0) return CH_A + 8'($urandom_range(25));
    do
      b = 8'($urandom_range(1, 255));
    while (ends_bare_ch(b) ||
           (first && (b == CH_QUOTE || b == CH_SLASH || b == CH_LBRACK || b == CH_LBRACE)));
    return b;
  endfunction

  function automatic logic [7:0] space_char();
    logic [7:0] pick[6] = '{CH_SP, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
    return pick[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] punct_char();
    logic [7:0] pick[7] = '{CH_EQ, CH_COMMA, CH_SEMI, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                            CH_RBRACE};
    return pick[$urandom_range(6)];
  endfunction

  // Quoted body, with escapes that may hide a quote or a backslash
  task automatic add_quoted_body(int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_QUOTE) b = CH_A;
      add_word(b, 1'b0);
      if (b == CH_BSLASH)
        add_word(($urandom_range(1) != 0) ? CH_QUOTE : 8'($urandom_range(1, 255)), 1'b0);
    end
  endtask

  // Block comment body rich in stars and slashes
  task automatic add_comment_body(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0:       add_word(CH_STAR, 1'b0);
        1:       add_word(CH_SLASH, 1'b0);
        default: add_word(8'($urandom_range(1, 255)), 1'b0);
      endcase
    end
  endtask

  // A well-formed config text with random content, ended in one of several ways
  task automatic add_config_text();
    int n_tokens;
    logic [7:0] b;
    n_tokens = $urandom_range(2, 10);
    for (int k = 0; k < n_tokens; k++) begin
      case ($urandom_range(6))
        0: add_word(punct_char(), 1'b0);
        1: begin
          add_word(bare_char(1'b1), 1'b0);
          repeat ($urandom_range(5)) add_word(bare_char(1'b0), 1'b0);
          add_word(($urandom_range(1) != 0) ? space_char() : punct_char(), 1'b0);
        end
        2: begin
          add_word(CH_QUOTE, 1'b0);
          add_quoted_body($urandom_range(6));
          add_word(CH_QUOTE, 1'b0);
        end
        3: begin
          add_word(CH_SLASH, 1'b0);
          add_word(CH_STAR, 1'b0);
          add_comment_body($urandom_range(6));
          add_word(CH_STAR, 1'b0);
          add_word(CH_SLASH, 1'b0);
        end
        4: begin
          add_word(CH_SLASH, 1'b0);
          add_word(CH_SLASH, 1'b0);
          repeat ($urandom_range(5)) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
            add_word(b, 1'b0);
          end
          add_word(CH_LF, 1'b0);
        end
        5: begin
          // lone slash, or a slash that opens a bare literal
          add_word(CH_SLASH, 1'b0);
          if ($urandom_range(1) != 0) add_word(bare_char(1'b1), 1'b0);
          add_word(($urandom_range(1) != 0) ? space_char() : punct_char(), 1'b0);
        end
        default: repeat ($urandom_range(1, 3)) add_word(space_char(), 1'b0);
      endcase
    end
    case ($urandom_range(9))
      0: add_word(CH_NUL, 1'b0);
      1: begin
        add_word(CH_QUOTE, 1'b0);
        add_quoted_body($urandom_range(3));
        add_end();
      end
      2: begin
        add_word(CH_SLASH, 1'b0);
        add_word(CH_STAR, 1'b0);
        add_comment_body($urandom_range(3));
        add_end();
      end
      3: begin
        add_word(bare_char(1'b1), 1'b0);
        add_end();
      end
      default: add_end();
    endcase
  endtask

  // Arbitrary bytes, zeros included
  task automatic add_noise_text();
    repeat ($urandom_range(1, 16)) add_word(8'($urandom_range(255)), 1'b0);
    add_end();
  endtask

  task automatic add_random_phase(int n_words);
    int goal;
    goal = pending_words.size() + n_words;
    while (pending_words.size() < goal) begin
      if ($urandom_range(99) < 15) add_noise_text();
      else add_config_text();
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_words);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_random_phase(n_words);
    wait (pending_words.size() == 0);
  endtask

  initial begin
    reset_lexer();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Empty text, then every punctuation with a lone slash and a top byte at end
    add_end();
    add_text("/;=,[]{}");
    add_word(8'hFF, 1'b0);
    add_end();
    // Tab, star-slash not closing early, escaped quote, line comment cut by a zero byte
    add_text("\t/*/*/\"\\\"\"//");
    add_word(CH_NUL, 1'b0);
    // End inside a string, then inside a block comment
    add_text("\"a");
    add_end();
    add_text("/*");
    add_end();

    // Long receiver hold-off while the sender keeps offering
    hold_armed = 1'b1;
    run_phase(0, 0, PHASE_WORDS);

    run_phase(84, 0, PHASE_WORDS);
    run_phase(0, 84, PHASE_WORDS);
    run_phase(7, 7, PHASE_WORDS);

    wait (!in_tvalid);
    wait (expected_tokens.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
